// ===== hw/rtl/uart_image_receive_with_crc_ack_defines.svh =====
// assertion macros shared by the image receiver modules
// expects clk and rst_n in the scope of each use
`ifndef UART_IMAGE_RECEIVE_WITH_CRC_ACK_DEFINES_SVH
`define UART_IMAGE_RECEIVE_WITH_CRC_ACK_DEFINES_SVH

// same-cycle implication, checked out of reset
`define UIRC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define UIRC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/uirc_pkg.sv =====
// types, codes and the crc byte update for the image receiver
// no dependencies
package uirc_pkg;

    // reply codes
    localparam logic [7:0] CODE_ACK  = 8'h06;
    localparam logic [7:0] CODE_NACK = 8'h15;
    localparam logic [7:0] CODE_EOT  = 8'h04;

    // input operations
    localparam logic [1:0] OP_BYTE    = 2'd0;
    localparam logic [1:0] OP_TIMEOUT = 2'd1;
    localparam logic [1:0] OP_START   = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_REPLY = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    // register indexes
    typedef enum logic [1:0] {
        REG_BLOCK_PAYLOAD = 2'd0,
        REG_FAIL_LIMIT    = 2'd1
    } reg_idx_t;

    localparam int          CFG_DATA_W         = 13;
    localparam int          PAYLOAD_LIMIT_DEF  = 4096;
    localparam logic [12:0] BLOCK_PAYLOAD_RST  = 13'd2048;
    localparam logic [2:0]  FAIL_LIMIT_RST     = 3'd3;
    localparam int          CRC_BYTES          = 4;
    localparam logic [31:0] CRC_POLY           = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT           = 32'hFFFFFFFF;
    localparam int          MAX_RESULTS        = 3;
    localparam int          QDEPTH             = 4;
    localparam int          QPTR_W             = 2;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] rx_byte;
    } in_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic       commit;
        logic       flush;
        logic       success;
        logic       last;
    } out_t;

    typedef struct packed {
        logic [12:0] block_payload;
        logic [2:0]  fail_limit;
    } cfg_t;

    // results caused by one item, in order
    typedef struct packed {
        logic [1:0]                 n;
        out_t [MAX_RESULTS-1:0]     r;
    } res_bundle_t;

    // reflected crc-32, one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic out_t mk_res(input logic [1:0] kind, input logic [7:0] value,
                                    input logic commit, input logic flush,
                                    input logic success);
        out_t r;
        r.kind    = kind;
        r.value   = value;
        r.commit  = commit;
        r.flush   = flush;
        r.success = success;
        r.last    = 1'b0;
        return r;
    endfunction

endpackage

// ===== hw/rtl/uart_image_receive_with_crc_ack.sv =====
// Image download receiver: size header, crc-checked blocks, ack/nack replies.
// Results: an item's results are registered into the result queue when it is accepted.
// Throughput: one item per cycle while results drain one per cycle; an item
// with two or three results holds the input until the queue holds at most one result.
// Reset: asynchronous, active low; idle session, block_payload 2048, fail limit 3.
module uart_image_receive_with_crc_ack
#(
    parameter int PAYLOAD_LIMIT = uirc_pkg::PAYLOAD_LIMIT_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  uirc_pkg::in_t                    in_item,
    output logic                             out_valid,
    input  logic                             out_stall,
    output uirc_pkg::out_t                   out_item,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [1:0]                       cfg_index,
    input  logic [uirc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    uirc_pkg::cfg_t        cfg;
    uirc_pkg::res_bundle_t res;
    logic                  acc;
    logic                  low_space;

    assign in_stall = low_space;
    assign acc      = in_valid && !in_stall;

    // configuration registers
    uirc_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // session state and result generation
    uirc_core #(.PAYLOAD_LIMIT(PAYLOAD_LIMIT)) u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .acc   (acc),
        .item  (in_item),
        .cfg   (cfg),
        .res   (res)
    );

    // result queue
    uirc_outq u_outq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .low_space (low_space),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

// ===== hw/rtl/uirc_cfg.sv =====
// configuration registers of the image receiver
// depends on uirc_pkg
module uirc_cfg
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [1:0]                       cfg_index,
    input  logic [uirc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output uirc_pkg::cfg_t                   cfg
);

    logic [12:0] block_payload_reg;
    logic [2:0]  fail_limit_reg;

    assign cfg_ready = 1'b1;

    // register write decode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_payload_reg <= uirc_pkg::BLOCK_PAYLOAD_RST;
            fail_limit_reg    <= uirc_pkg::FAIL_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                uirc_pkg::REG_BLOCK_PAYLOAD: block_payload_reg <= cfg_data[12:0];
                uirc_pkg::REG_FAIL_LIMIT:    fail_limit_reg    <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    assign cfg.block_payload = block_payload_reg;
    assign cfg.fail_limit    = fail_limit_reg;

endmodule

// ===== hw/rtl/uirc_core.sv =====
// session and block state of the image receiver, one item per cycle while the input is not stalled
// depends on uirc_pkg and the assertion macro header
`include "uart_image_receive_with_crc_ack_defines.svh"
module uirc_core
#(
    parameter int PAYLOAD_LIMIT = uirc_pkg::PAYLOAD_LIMIT_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  acc,
    input  uirc_pkg::in_t         item,
    input  uirc_pkg::cfg_t        cfg,
    output uirc_pkg::res_bundle_t res
);

    localparam int PL_W  = $clog2(PAYLOAD_LIMIT + 1);
    localparam int CNT_W = $clog2(PAYLOAD_LIMIT + 6);

    typedef enum logic [1:0] {PH_IDLE, PH_HEADER, PH_BLOCK} phase_t;

    phase_t             phase_reg, phase_next;
    logic [1:0]         hdr_reg, hdr_next;
    logic [31:0]        size_reg, size_next;
    logic [31:0]        remaining_reg, remaining_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               failed_reg, failed_next;
    logic [2:0]         tmo_reg, tmo_next;
    logic [2:0]         fcnt_reg, fcnt_next;
    logic [31:0]        crc_reg, crc_next;
    logic [31:0]        crc_rx_reg, crc_rx_next;

    logic [12:0]        bp_nz;
    logic [PL_W-1:0]    bp_eff;
    logic [PL_W-1:0]    payload;
    logic [2:0]         lim;
    logic [2:0]         tmo_inc;
    logic [2:0]         fcnt_inc;
    logic [CNT_W-1:0]   cnt_inc;
    logic               fail_req;
    logic               fail_flush;
    logic [1:0]         res_n;
    uirc_pkg::out_t [uirc_pkg::MAX_RESULTS-1:0] res_r;

    // effective block length and retry limit
    always_comb
    begin
        bp_nz = (cfg.block_payload == 13'd0) ? 13'd1 : cfg.block_payload;
        if (32'(bp_nz) > 32'(PAYLOAD_LIMIT))
            bp_eff = PL_W'(PAYLOAD_LIMIT);
        else
            bp_eff = PL_W'(bp_nz);
        if (remaining_reg < 32'(bp_eff))
            payload = PL_W'(remaining_reg);
        else
            payload = bp_eff;
        lim = (cfg.fail_limit == 3'd0) ? 3'd1 : cfg.fail_limit;
    end

    assign tmo_inc  = (tmo_reg == 3'd7) ? tmo_reg : tmo_reg + 3'd1;
    assign fcnt_inc = (fcnt_reg == 3'd7) ? fcnt_reg : fcnt_reg + 3'd1;
    assign cnt_inc  = cnt_reg + CNT_W'(1);

    // next state and results of the accepted item
    always_comb
    begin
        phase_next     = phase_reg;
        hdr_next       = hdr_reg;
        size_next      = size_reg;
        remaining_next = remaining_reg;
        cnt_next       = cnt_reg;
        failed_next    = failed_reg;
        tmo_next       = tmo_reg;
        fcnt_next      = fcnt_reg;
        crc_next       = crc_reg;
        crc_rx_next    = crc_rx_reg;
        fail_req       = 1'b0;
        fail_flush     = 1'b0;
        res_n          = 2'd0;
        res_r          = '0;

        if (acc)
        begin
            case (item.op)
                uirc_pkg::OP_START:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        phase_next     = PH_HEADER;
                        hdr_next       = 2'd0;
                        size_next      = 32'd0;
                        remaining_next = 32'd0;
                        fcnt_next      = 3'd0;
                        cnt_next       = '0;
                        failed_next    = 1'b0;
                        tmo_next       = 3'd0;
                        crc_next       = uirc_pkg::CRC_INIT;
                        crc_rx_next    = 32'd0;
                    end
                end
                uirc_pkg::OP_TIMEOUT:
                begin
                    if (phase_reg == PH_HEADER)
                    begin
                        res_r[res_n] = uirc_pkg::mk_res(uirc_pkg::KIND_END, 8'd0,
                                                        1'b0, 1'b0, 1'b0);
                        res_n      = res_n + 2'd1;
                        phase_next = PH_IDLE;
                    end
                    else if (phase_reg == PH_BLOCK)
                    begin
                        failed_next = 1'b1;
                        tmo_next    = tmo_inc;
                        if (tmo_inc >= lim)
                        begin
                            fail_req   = 1'b1;
                            fail_flush = 1'b1;
                        end
                    end
                end
                uirc_pkg::OP_BYTE:
                begin
                    if (phase_reg == PH_HEADER)
                    begin
                        // size header, little endian
                        size_next = size_reg | (32'(item.rx_byte) << {hdr_reg, 3'b000});
                        hdr_next  = hdr_reg + 2'd1;
                        if (hdr_reg == 2'd3)
                        begin
                            if (size_next == 32'd0)
                            begin
                                res_r[res_n] = uirc_pkg::mk_res(uirc_pkg::KIND_END, 8'd0,
                                                                1'b0, 1'b0, 1'b0);
                                res_n      = res_n + 2'd1;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                res_r[res_n] = uirc_pkg::mk_res(uirc_pkg::KIND_REPLY,
                                                                uirc_pkg::CODE_ACK,
                                                                1'b0, 1'b0, 1'b0);
                                res_n          = res_n + 2'd1;
                                phase_next     = PH_BLOCK;
                                remaining_next = size_next;
                                cnt_next       = '0;
                                failed_next    = 1'b0;
                                tmo_next       = 3'd0;
                                crc_next       = uirc_pkg::CRC_INIT;
                                crc_rx_next    = 32'd0;
                            end
                        end
                    end
                    else if (phase_reg == PH_BLOCK)
                    begin
                        if (cnt_reg < CNT_W'(payload))
                        begin
                            // payload byte
                            crc_next     = uirc_pkg::crc_byte(crc_reg, item.rx_byte);
                            res_r[res_n] = uirc_pkg::mk_res(uirc_pkg::KIND_DATA,
                                                            item.rx_byte,
                                                            1'b0, 1'b0, 1'b0);
                            res_n    = res_n + 2'd1;
                            cnt_next = cnt_inc;
                        end
                        else
                        begin
                            // crc trailer byte
                            crc_rx_next = {item.rx_byte, crc_rx_reg[31:8]};
                            cnt_next    = cnt_inc;
                            if (cnt_inc >= CNT_W'(payload) + CNT_W'(uirc_pkg::CRC_BYTES))
                            begin
                                if (failed_reg)
                                begin
                                    fail_req   = 1'b1;
                                    fail_flush = 1'b1;
                                end
                                else if (~crc_reg == crc_rx_next)
                                begin
                                    fcnt_next      = 3'd0;
                                    remaining_next = remaining_reg - 32'(payload);
                                    cnt_next       = '0;
                                    failed_next    = 1'b0;
                                    tmo_next       = 3'd0;
                                    crc_next       = uirc_pkg::CRC_INIT;
                                    crc_rx_next    = 32'd0;
                                    res_r[res_n] = uirc_pkg::mk_res(uirc_pkg::KIND_REPLY,
                                                                    uirc_pkg::CODE_ACK,
                                                                    1'b1, 1'b0, 1'b0);
                                    res_n = res_n + 2'd1;
                                    if (remaining_reg == 32'(payload))
                                    begin
                                        res_r[res_n] = uirc_pkg::mk_res(
                                            uirc_pkg::KIND_REPLY, uirc_pkg::CODE_EOT,
                                            1'b0, 1'b0, 1'b0);
                                        res_n = res_n + 2'd1;
                                        res_r[res_n] = uirc_pkg::mk_res(
                                            uirc_pkg::KIND_END, 8'd0, 1'b0, 1'b0, 1'b1);
                                        res_n      = res_n + 2'd1;
                                        phase_next = PH_IDLE;
                                    end
                                end
                                else
                                begin
                                    fail_req = 1'b1;
                                end
                            end
                        end
                    end
                end
                default: ;
            endcase

            // failed block: nack, then abort once the limit is hit
            if (fail_req)
            begin
                res_r[res_n] = uirc_pkg::mk_res(uirc_pkg::KIND_REPLY, uirc_pkg::CODE_NACK,
                                                1'b0, fail_flush, 1'b0);
                res_n       = res_n + 2'd1;
                cnt_next    = '0;
                failed_next = 1'b0;
                tmo_next    = 3'd0;
                crc_next    = uirc_pkg::CRC_INIT;
                crc_rx_next = 32'd0;
                fcnt_next   = fcnt_inc;
                if (fcnt_inc >= lim)
                begin
                    res_r[res_n] = uirc_pkg::mk_res(uirc_pkg::KIND_END, 8'd0,
                                                    1'b0, 1'b0, 1'b0);
                    res_n      = res_n + 2'd1;
                    phase_next = PH_IDLE;
                end
            end
        end

        // mark the final result of the item
        if (res_n != 2'd0)
            res_r[res_n - 2'd1].last = 1'b1;
    end

    assign res.n = res_n;
    assign res.r = res_r;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            hdr_reg       <= 2'd0;
            size_reg      <= 32'd0;
            remaining_reg <= 32'd0;
            cnt_reg       <= '0;
            failed_reg    <= 1'b0;
            tmo_reg       <= 3'd0;
            fcnt_reg      <= 3'd0;
            crc_reg       <= uirc_pkg::CRC_INIT;
            crc_rx_reg    <= 32'd0;
        end
        else
        begin
            phase_reg     <= phase_next;
            hdr_reg       <= hdr_next;
            size_reg      <= size_next;
            remaining_reg <= remaining_next;
            cnt_reg       <= cnt_next;
            failed_reg    <= failed_next;
            tmo_reg       <= tmo_next;
            fcnt_reg      <= fcnt_next;
            crc_reg       <= crc_next;
            crc_rx_reg    <= crc_rx_next;
        end
    end

    // a block phase always has bytes still to come
    `UIRC_ASSERT_IMPL(a_block_remaining, phase_reg == PH_BLOCK, remaining_reg != 32'd0,
        "block phase with nothing remaining")
    // a failed mark only lives inside a block
    `UIRC_ASSERT_IMPL(a_failed_phase, failed_reg, phase_reg == PH_BLOCK,
        "block failure mark outside block phase")
    // a good block that ends the image closes the session
    `UIRC_ASSERT_NEXT(a_eot_idle, acc && res.n == 2'd3 && res.r[1].value == uirc_pkg::CODE_EOT,
        phase_reg == PH_IDLE, "session still open after eot")

endmodule

// ===== hw/rtl/uirc_outq.sv =====
// result queue of the image receiver, takes up to three results a cycle
// depends on uirc_pkg and the assertion macro header
`include "uart_image_receive_with_crc_ack_defines.svh"
module uirc_outq
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  uirc_pkg::res_bundle_t res,
    output logic                  low_space,
    output logic                  out_valid,
    input  logic                  out_stall,
    output uirc_pkg::out_t        out_item
);

    localparam int CNT_W = $clog2(uirc_pkg::QDEPTH + 1);

    uirc_pkg::out_t               mem [uirc_pkg::QDEPTH];
    logic [uirc_pkg::QPTR_W-1:0]  wr_reg, wr_next;
    logic [uirc_pkg::QPTR_W-1:0]  rd_reg, rd_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic                         pop;

    // room for a worst-case item only
    assign low_space = cnt_reg > CNT_W'(uirc_pkg::QDEPTH - uirc_pkg::MAX_RESULTS);
    assign out_valid = cnt_reg != '0;
    assign out_item  = mem[rd_reg];
    assign pop       = out_valid && !out_stall;

    // pointer and fill update
    always_comb
    begin
        wr_next  = wr_reg + uirc_pkg::QPTR_W'(res.n);
        rd_next  = pop ? rd_reg + uirc_pkg::QPTR_W'(1) : rd_reg;
        cnt_next = cnt_reg + CNT_W'(res.n) - CNT_W'(pop);
    end

    // result storage
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < uirc_pkg::MAX_RESULTS; k++)
        begin
            if (k < int'(res.n))
                mem[wr_reg + uirc_pkg::QPTR_W'(k)] <= res.r[k];
        end
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // fill never passes the depth
    `UIRC_ASSERT_IMPL(a_no_overflow, 1'b1, cnt_reg <= CNT_W'(uirc_pkg::QDEPTH),
        "result queue overflow")
    // fill tracks pushes in cycles without a pop
    `UIRC_ASSERT_NEXT(a_fill_track, !pop,
        cnt_reg == $past(cnt_reg) + CNT_W'($past(res.n)), "result queue fill mismatch")
    // pointers stay a fill apart
    `UIRC_ASSERT_IMPL(a_ptr_gap, 1'b1,
        wr_reg == rd_reg + uirc_pkg::QPTR_W'(cnt_reg), "queue pointers inconsistent")

endmodule
